// ----- hw/rtl/drbcg_pkg.sv -----
// Package for the DRAM row-buffer command generator.
// Request and result types, microcode word layout and command codes.
// No dependencies.
`timescale 1ns / 1ps

package drbcg_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int RANK_COUNT   = 2;
  localparam int NUM_BANKS    = 8;
  localparam int ROW_BITS     = 14;
  localparam int COL_BITS     = 10;

  localparam int ROW_W = 14;
  localparam int COL_W = 10;

  // Indexes reachable through the request fields.
  localparam int CH_USED = (NUM_CHANNELS < 2) ? NUM_CHANNELS : 2;
  localparam int RK_USED = (RANK_COUNT < 2) ? RANK_COUNT : 2;
  localparam int BK_USED = (NUM_BANKS < 8) ? NUM_BANKS : 8;
  localparam int ENTRIES = CH_USED * RK_USED * BK_USED;
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [ROW_W-1:0] ROW_MASK =
    (ROW_BITS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << ROW_BITS) - 1);
  localparam logic [COL_W-1:0] COL_MASK =
    (COL_BITS >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << COL_BITS) - 1);

  localparam logic [1:0] CMD_PRE = 2'd0;
  localparam logic [1:0] CMD_ACT = 2'd1;
  localparam logic [1:0] CMD_RD  = 2'd2;
  localparam logic [1:0] CMD_WR  = 2'd3;

  localparam logic [1:0] SEL_PRE = 2'd0;
  localparam logic [1:0] SEL_ACT = 2'd1;
  localparam logic [1:0] SEL_ACC = 2'd2;

  localparam logic [1:0] UPD_NONE  = 2'd0;
  localparam logic [1:0] UPD_OPEN  = 2'd1;
  localparam logic [1:0] UPD_CLOSE = 2'd2;

  localparam logic [1:0] JMP_NEXT = 2'd0;
  localparam logic [1:0] JMP_WAIT = 2'd1;
  localparam logic [1:0] JMP_DISP = 2'd2;

  localparam int STEP_W = 4;

  typedef struct packed {
    logic             kind;
    logic             channel;
    logic             rank;
    logic [2:0]       bank;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } req_t;

  typedef struct packed {
    logic [1:0]       command;
    logic             cmd_channel;
    logic             cmd_rank;
    logic [2:0]       cmd_bank;
    logic [ROW_W-1:0] cmd_row;
    logic [COL_W-1:0] cmd_column;
    logic             last;
  } result_t;

  typedef struct packed {
    logic              emit;
    logic [1:0]        sel;
    logic              last;
    logic [1:0]        upd;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] next;
  } ucode_t;

  typedef struct packed {
    logic close_policy;
    logic is_open;
    logic row_hit;
  } seq_cond_t;

  typedef struct packed {
    logic               set_open;
    logic               clear_open;
    logic [ENTRY_W-1:0] idx;
    logic [ROW_W-1:0]   row;
  } bank_wr_t;

  typedef struct packed {
    logic is_open;
    logic row_hit;
  } bank_status_t;

  // Wrap a small index into [0, m) by repeated subtraction.
  function automatic logic [2:0] wrap_idx(logic [2:0] v, logic [4:0] m);
    logic [4:0] r;
    r = {2'b00, v};
    for (int i = 0; i < 7; i++) begin
      if (r >= m) r = r - m;
    end
    return r[2:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] entry_index(logic ch, logic rk, logic [2:0] bk);
    int unsigned tmp;
    tmp = (32'(ch) * RK_USED + 32'(rk)) * BK_USED + 32'(bk);
    return ENTRY_W'(tmp);
  endfunction

endpackage

// ----- hw/rtl/drbcg_bank_state.sv -----
// Per-bank row-buffer state: open flags in flops, open row numbers in a memory.
// Registered lookup at request accept, update from the sequencer.
// Depends on drbcg_pkg.
`timescale 1ns / 1ps

module drbcg_bank_state
  import drbcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               lookup,
  input  logic [ENTRY_W-1:0] lookup_idx,
  input  logic [ROW_W-1:0]   cur_row,
  input  bank_wr_t           wr,
  output bank_status_t       status
);

  logic [ENTRIES-1:0] open_flags;
  logic [ROW_W-1:0]   row_mem [ENTRIES];
  logic [ROW_W-1:0]   rd_row;
  logic               rd_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flags <= '0;
    end else if (wr.set_open) begin
      open_flags[wr.idx] <= 1'b1;
    end else if (wr.clear_open) begin
      open_flags[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_open <= 1'b0;
    end else if (lookup) begin
      rd_open <= open_flags[lookup_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_open) begin
      row_mem[wr.idx] <= wr.row;
    end
    if (lookup) begin
      rd_row <= row_mem[lookup_idx];
    end
  end

  assign status.is_open = rd_open;
  assign status.row_hit = rd_open && (rd_row == cur_row);

endmodule

// ----- hw/rtl/drbcg_sequencer.sv -----
// Microcoded sequencer: step counter, control store and jump logic.
// One control word per step drives the command datapath and state update.
// Depends on drbcg_pkg.
`timescale 1ns / 1ps

module drbcg_sequencer
  import drbcg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  seq_cond_t cond,
  output ucode_t    uc,
  output logic      busy
);

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISP      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CONF_PRE  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MISS_ACT  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_OPEN_ACC  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HIT_ACC   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CLOSE_ACT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CLOSE_ACC = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CLOSE_PRE = 4'd8;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  // Control store: emit, sel, last, upd, jmp, next.
  always_comb begin
    unique case (step)
      STEP_IDLE:      uc = '{1'b0, SEL_PRE, 1'b0, UPD_NONE,  JMP_WAIT, STEP_DISP};
      STEP_DISP:      uc = '{1'b0, SEL_PRE, 1'b0, UPD_NONE,  JMP_DISP, STEP_IDLE};
      STEP_CONF_PRE:  uc = '{1'b1, SEL_PRE, 1'b0, UPD_NONE,  JMP_NEXT, STEP_MISS_ACT};
      STEP_MISS_ACT:  uc = '{1'b1, SEL_ACT, 1'b0, UPD_NONE,  JMP_NEXT, STEP_OPEN_ACC};
      STEP_OPEN_ACC:  uc = '{1'b1, SEL_ACC, 1'b1, UPD_OPEN,  JMP_NEXT, STEP_IDLE};
      STEP_HIT_ACC:   uc = '{1'b1, SEL_ACC, 1'b1, UPD_NONE,  JMP_NEXT, STEP_IDLE};
      STEP_CLOSE_ACT: uc = '{1'b1, SEL_ACT, 1'b0, UPD_NONE,  JMP_NEXT, STEP_CLOSE_ACC};
      STEP_CLOSE_ACC: uc = '{1'b1, SEL_ACC, 1'b0, UPD_NONE,  JMP_NEXT, STEP_CLOSE_PRE};
      STEP_CLOSE_PRE: uc = '{1'b1, SEL_PRE, 1'b1, UPD_CLOSE, JMP_NEXT, STEP_IDLE};
      default:        uc = '{1'b0, SEL_PRE, 1'b0, UPD_NONE,  JMP_NEXT, STEP_IDLE};
    endcase
  end

  always_comb begin
    case (uc.jmp)
      JMP_WAIT: step_next = accept ? uc.next : step;
      JMP_DISP: begin
        if (cond.close_policy) step_next = STEP_CLOSE_ACT;
        else if (cond.row_hit) step_next = STEP_HIT_ACC;
        else if (cond.is_open) step_next = STEP_CONF_PRE;
        else                   step_next = STEP_MISS_ACT;
      end
      default:  step_next = uc.next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign busy = (step != STEP_IDLE);

endmodule

// ----- hw/rtl/dram_row_buffer_command_generator_top.sv -----
// DRAM row-buffer command generator, top level.
// Request register, command datapath, policy register; instantiates the
// sequencer and bank state. Depends on drbcg_pkg.
//
// Usage:
//  - A request (req) is taken at a rising edge with start high and busy low.
//  - Each DRAM command appears on result for exactly one cycle with
//    result_valid high; result.last marks the final command of a request.
//    The receiver cannot stall the block and must take every command.
//  - A request yields 1 command on an open-page row hit, 2 on a miss to a
//    closed bank, 3 on a row conflict and 3 in close-page mode.
//  - The first command is driven from the result register after the lookup
//    step and the first command step; the commands of one request come out on
//    consecutive cycles.
//  - busy stays high from accept through the lookup step and the command
//    steps, so a new request waits until busy falls: one lookup step for
//    the registered row-table read, then one sequencer step per command.
//  - policy_we/policy_wdata write the page policy (0 open, 1 close); do so
//    only while the block is idle, the block itself does not enforce it.
//  - Synchronous reset closes all banks, selects open-page policy and
//    returns the sequencer to idle.
`timescale 1ns / 1ps

module dram_row_buffer_command_generator_top
  import drbcg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  input  logic    policy_we,
  input  logic    policy_wdata,
  output logic    result_valid,
  output result_t result
);

  logic               accept;
  logic               policy;
  req_t               req_q;
  logic [ENTRY_W-1:0] idx_q;
  req_t               req_w;
  logic [ENTRY_W-1:0] idx_w;
  ucode_t             uc;
  seq_cond_t          cond;
  bank_wr_t           wr;
  bank_status_t       status;
  result_t            result_next;

  assign accept = start && !busy;

  always_comb begin
    req_w         = req;
    req_w.channel = wrap_idx({2'b00, req.channel}, 5'(NUM_CHANNELS)) != 3'd0;
    req_w.rank    = wrap_idx({2'b00, req.rank}, 5'(RANK_COUNT)) != 3'd0;
    req_w.bank    = wrap_idx(req.bank, 5'(NUM_BANKS));
    req_w.row     = req.row & ROW_MASK;
    req_w.column  = req.column & COL_MASK;
    idx_w         = entry_index(req_w.channel, req_w.rank, req_w.bank);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
    end else if (policy_we) begin
      policy <= policy_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_w;
      idx_q <= idx_w;
    end
  end

  drbcg_bank_state u_bank_state (
    .clk        (clk),
    .rst        (rst),
    .lookup     (accept),
    .lookup_idx (idx_w),
    .cur_row    (req_q.row),
    .wr         (wr),
    .status     (status)
  );

  assign cond.close_policy = policy;
  assign cond.is_open      = status.is_open;
  assign cond.row_hit      = status.row_hit;

  drbcg_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cond   (cond),
    .uc     (uc),
    .busy   (busy)
  );

  assign wr.set_open   = (uc.upd == UPD_OPEN);
  assign wr.clear_open = (uc.upd == UPD_CLOSE);
  assign wr.idx        = idx_q;
  assign wr.row        = req_q.row;

  always_comb begin
    result_next             = '0;
    result_next.cmd_channel = req_q.channel;
    result_next.cmd_rank    = req_q.rank;
    result_next.cmd_bank    = req_q.bank;
    result_next.last        = uc.last;
    case (uc.sel)
      SEL_ACT: begin
        result_next.command = CMD_ACT;
        result_next.cmd_row = req_q.row;
      end
      SEL_ACC: begin
        result_next.command    = req_q.kind ? CMD_WR : CMD_RD;
        result_next.cmd_column = req_q.column;
      end
      default: result_next.command = CMD_PRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= uc.emit;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("command after last of a request");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("gap inside a command burst");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("request accepted before burst finished");

  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    accept |=> !result_valid ##1 !result_valid)
    else $error("command during lookup");

endmodule

// ----- tb/sv/dram_row_buffer_command_generator_top_test.sv -----
// Testbench for the DRAM row-buffer command generator top level.
// Runs a directed request table, then random request phases under both page policies,
// and checks every command against the table's typed codes or its own bank-state predictor. Depends on drbcg_pkg.
`timescale 1ns / 1ps

module dram_row_buffer_command_generator_top_test;
  import drbcg_pkg::*;

  localparam int BANK_SLOTS = NUM_CHANNELS * RANK_COUNT * NUM_BANKS;
  localparam int DIR_STEPS = 16;
  localparam int PHASES = 5;
  localparam int PHASE_REQUESTS = 20;

  typedef struct packed {
    logic       policy;
    req_t       rq;
    logic [1:0] n_typed;
    logic [5:0] typed_codes;
  } dir_step_t;

  logic    clk;
  logic    rst;
  logic    start;
  req_t    req;
  logic    busy;
  logic    policy_we;
  logic    policy_wdata;
  logic    result_valid;
  result_t result;

  result_t          pending_cmds[$];
  result_t          row_cmds[$];
  logic             bank_is_open[BANK_SLOTS];
  logic [ROW_W-1:0] bank_row[BANK_SLOTS];
  logic             policy_mode;
  logic [ROW_W-1:0] hot_rows[3];
  req_t             last_req;
  bit               no_gaps;
  int               fails;
  dir_step_t        script[DIR_STEPS];

  dram_row_buffer_command_generator_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .policy_we    (policy_we),
    .policy_wdata (policy_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  function automatic result_t build_command(logic [1:0] code, req_t r, logic fin);
    result_t c;
    c.command     = code;
    c.cmd_channel = 1'(r.channel % NUM_CHANNELS);
    c.cmd_rank    = 1'(r.rank % RANK_COUNT);
    c.cmd_bank    = 3'(r.bank % NUM_BANKS);
    c.cmd_row     = (code == CMD_ACT) ? (r.row & ROW_MASK) : '0;
    c.cmd_column  = (code == CMD_RD || code == CMD_WR) ? (r.column & COL_MASK) : '0;
    c.last        = fin;
    return c;
  endfunction

  // Work out the command sequence of a request and advance the bank state.
  task automatic predict_request(req_t r);
    int               slot;
    logic [1:0]       access;
    logic [ROW_W-1:0] row_used;
    slot = ((int'(r.channel % NUM_CHANNELS) * RANK_COUNT + int'(r.rank % RANK_COUNT))
            * NUM_BANKS) + int'(r.bank % NUM_BANKS);
    access = r.kind ? CMD_WR : CMD_RD;
    row_used = r.row & ROW_MASK;
    row_cmds.delete();
    if (policy_mode) begin
      row_cmds.push_back(build_command(CMD_ACT, r, 1'b0));
      row_cmds.push_back(build_command(access, r, 1'b0));
      row_cmds.push_back(build_command(CMD_PRE, r, 1'b1));
      bank_is_open[slot] = 1'b0;
    end else if (bank_is_open[slot] && bank_row[slot] == row_used) begin
      row_cmds.push_back(build_command(access, r, 1'b1));
    end else begin
      if (bank_is_open[slot]) row_cmds.push_back(build_command(CMD_PRE, r, 1'b0));
      row_cmds.push_back(build_command(CMD_ACT, r, 1'b0));
      row_cmds.push_back(build_command(access, r, 1'b1));
      bank_is_open[slot] = 1'b1;
      bank_row[slot] = row_used;
    end
  endtask

  task automatic send_request(req_t r, logic [1:0] n_typed, logic [5:0] codes);
    int i;
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    req = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
    if (n_typed == 0) begin
      foreach (row_cmds[i]) pending_cmds.push_back(row_cmds[i]);
    end else begin
      for (i = 0; i < n_typed; i++) begin
        pending_cmds.push_back(build_command(codes[5 - 2 * i -: 2], r, i == n_typed - 1));
      end
    end
    last_req = r;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic set_policy(logic p);
    while (pending_cmds.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    policy_we = 1'b1;
    policy_wdata = p;
    @(negedge clk);
    policy_we = 1'b0;
    policy_mode = p;
  endtask

  function automatic dir_step_t mk(logic p, logic k, logic ch, logic rk, logic [2:0] bk,
                                   logic [ROW_W-1:0] rw, logic [COL_W-1:0] col,
                                   logic [1:0] n, logic [1:0] c0, logic [1:0] c1,
                                   logic [1:0] c2);
    dir_step_t s;
    s.policy = p;
    s.rq = '{kind: k, channel: ch, rank: rk, bank: bk, row: rw, column: col};
    s.n_typed = n;
    s.typed_codes = {c0, c1, c2};
    return s;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.kind    = 1'($urandom_range(0, 1));
    r.channel = 1'($urandom_range(0, 1));
    r.rank    = 1'($urandom_range(0, 1));
    r.bank    = 3'($urandom_range(0, 7));
    r.row     = ($urandom_range(0, 99) < 70) ? hot_rows[$urandom_range(0, 2)]
                                             : ROW_W'($urandom);
    r.column  = COL_W'($urandom);
    // Revisit the previous bank and row to build hit runs.
    if ($urandom_range(0, 99) < 25) begin
      r.channel = last_req.channel;
      r.rank    = last_req.rank;
      r.bank    = last_req.bank;
      r.row     = last_req.row;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with nothing pending", longint'(result), 64'd0);
      end else begin
        want = pending_cmds.pop_front();
        if (result.command !== want.command)
          report_mismatch("command", longint'(result.command), longint'(want.command));
        if (result.cmd_channel !== want.cmd_channel)
          report_mismatch("cmd_channel", longint'(result.cmd_channel),
                          longint'(want.cmd_channel));
        if (result.cmd_rank !== want.cmd_rank)
          report_mismatch("cmd_rank", longint'(result.cmd_rank), longint'(want.cmd_rank));
        if (result.cmd_bank !== want.cmd_bank)
          report_mismatch("cmd_bank", longint'(result.cmd_bank), longint'(want.cmd_bank));
        if (result.cmd_row !== want.cmd_row)
          report_mismatch("cmd_row", longint'(result.cmd_row), longint'(want.cmd_row));
        if (result.cmd_column !== want.cmd_column)
          report_mismatch("cmd_column", longint'(result.cmd_column),
                          longint'(want.cmd_column));
        if (result.last !== want.last)
          report_mismatch("last", longint'(result.last), longint'(want.last));
      end
    end
  end

  initial begin
    int   k;
    int   p;
    int   n;
    int   waited;
    logic phase_policy;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    policy_we = 1'b0;
    policy_wdata = 1'b0;
    policy_mode = 1'b0;
    no_gaps = 1'b0;
    fails = 0;
    last_req = '0;
    for (k = 0; k < BANK_SLOTS; k++) begin
      bank_is_open[k] = 1'b0;
      bank_row[k] = '0;
    end

    script[0]  = mk(0, 0, 0, 0, 0, 14'd0, 10'd0, 2, CMD_ACT, CMD_RD, CMD_PRE);
    script[1]  = mk(0, 0, 0, 0, 0, 14'd0, 10'd1023, 1, CMD_RD, CMD_PRE, CMD_PRE);
    script[2]  = mk(0, 1, 0, 0, 0, 14'd16383, 10'd0, 3, CMD_PRE, CMD_ACT, CMD_WR);
    script[3]  = mk(0, 1, 1, 1, 7, 14'd16383, 10'd1023, 2, CMD_ACT, CMD_WR, CMD_PRE);
    script[4]  = mk(0, 0, 1, 1, 7, 14'd16383, 10'd512, 1, CMD_RD, CMD_PRE, CMD_PRE);
    script[5]  = mk(0, 0, 1, 0, 3, 14'h2AAA, 10'h155, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[6]  = mk(0, 1, 0, 1, 5, 14'h1555, 10'h2AA, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[7]  = mk(0, 0, 1, 0, 3, 14'h1555, 10'h3C3, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[8]  = mk(1, 0, 0, 0, 0, 14'd100, 10'd7, 3, CMD_ACT, CMD_RD, CMD_PRE);
    script[9]  = mk(1, 1, 1, 1, 7, 14'd16383, 10'd1023, 3, CMD_ACT, CMD_WR, CMD_PRE);
    script[10] = mk(1, 1, 1, 0, 3, 14'd0, 10'd0, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[11] = mk(0, 0, 0, 0, 0, 14'd16383, 10'd0, 2, CMD_ACT, CMD_RD, CMD_PRE);
    script[12] = mk(0, 0, 1, 1, 7, 14'd16383, 10'd0, 2, CMD_ACT, CMD_RD, CMD_PRE);
    script[13] = mk(0, 1, 0, 1, 5, 14'h1555, 10'd1, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[14] = mk(0, 0, 1, 0, 3, 14'h2AAA, 10'h0F0, 0, CMD_PRE, CMD_PRE, CMD_PRE);
    script[15] = mk(0, 0, 0, 0, 0, 14'd16383, 10'd1023, 1, CMD_RD, CMD_PRE, CMD_PRE);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_policy(1'b0);
    for (k = 0; k < DIR_STEPS; k++) begin
      if (script[k].policy != policy_mode) set_policy(script[k].policy);
      send_request(script[k].rq, script[k].n_typed, script[k].typed_codes);
    end

    n = 0;
    for (p = 0; p < PHASES; p++) begin
      phase_policy = (p == 1) ? 1'b1 : (p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      set_policy(phase_policy);
      hot_rows[0] = ROW_W'($urandom);
      hot_rows[1] = ROW_W'($urandom);
      hot_rows[2] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        no_gaps = (n >= 40 && n < 75);
        send_request(random_request(), 2'd0, 6'd0);
        n++;
      end
    end
    no_gaps = 1'b0;

    waited = 0;
    while (pending_cmds.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_cmds.size() != 0)
      report_mismatch("commands never issued", longint'(pending_cmds.size()), 64'd0);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
